// ----- rtl/rnra_pkg.sv -----
`default_nettype none

package rnra_pkg;

	typedef enum logic [1:0] {
		AS_THINKING = 2'd0,
		AS_HUNGRY   = 2'd1,
		AS_EATING   = 2'd2
	} agent_st_t;

	typedef enum logic {
		DIR_LEFT  = 1'b0,
		DIR_RIGHT = 1'b1
	} dir_t;

	typedef enum logic [1:0] {
		PH_SELF  = 2'd0,
		PH_LEFT  = 2'd1,
		PH_RIGHT = 2'd2
	} phase_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LEFT,
		S_RIGHT,
		S_CHK_L,
		S_CHK_LW,
		S_CHK_R,
		S_CHK_RW,
		S_TRY_RL,
		S_TRY_RR,
		S_TRY_EVAL,
		S_DONE
	} seq_st_t;

	typedef struct packed {
		logic self_g;
		logic left_g;
		logic right_g;
		logic bad;
	} rnra_res_t;

	localparam int unsigned CountW   = 5;
	localparam int unsigned AgentW   = 4;
	localparam int unsigned IdxOutW  = 4;
	localparam logic [CountW-1:0] CountReset = 5'd5;

endpackage

`default_nettype wire

// ----- rtl/rnra_nbr.sv -----
`default_nettype none

module rnra_nbr
	import rnra_pkg::*;
#(
	parameter int unsigned MAX_AGENTS = 16,
	parameter int unsigned AW = $clog2(MAX_AGENTS),
	parameter int unsigned NW = AW + 1
) (
	input  wire logic [AW-1:0] idx,
	input  wire logic [NW-1:0] n,
	input  wire dir_t          dir,
	output logic      [AW-1:0] nbr
);

	logic [NW-1:0] idx_w;
	logic [NW-1:0] dec_w;
	logic [NW-1:0] inc_w;
	logic [NW-1:0] res_w;

	assign idx_w = {1'b0, idx};
	assign dec_w = idx_w - NW'(1);
	assign inc_w = idx_w + NW'(1);

	always_comb begin
		unique case (dir)
			DIR_LEFT:  res_w = (idx_w == '0) ? (n - NW'(1)) : dec_w;
			DIR_RIGHT: res_w = (inc_w == n) ? '0 : inc_w;
			default:   res_w = '0;
		endcase
	end

	assign nbr = res_w[AW-1:0];

endmodule

`default_nettype wire

// ----- rtl/rnra_state_mem.sv -----
`default_nettype none

module rnra_state_mem
	import rnra_pkg::*;
#(
	parameter int unsigned MAX_AGENTS = 16,
	parameter int unsigned AW = $clog2(MAX_AGENTS)
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      we,
	input  wire logic [AW-1:0] waddr,
	input  wire agent_st_t wdata,
	input  wire logic [AW-1:0] raddr,
	output agent_st_t      rdata
);

	agent_st_t               mem_q [MAX_AGENTS];
	agent_st_t               rdata_q;
	logic [MAX_AGENTS-1:0]   vld_q;
	logic                    rvld_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			rvld_q <= vld_q[raddr];
		end
	end

	assign rdata = rvld_q ? rdata_q : AS_THINKING;

endmodule

`default_nettype wire

// ----- rtl/rnra_seq.sv -----
`default_nettype none

module rnra_seq
	import rnra_pkg::*;
#(
	parameter int unsigned MAX_AGENTS = 16,
	parameter int unsigned AW = $clog2(MAX_AGENTS),
	parameter int unsigned NW = AW + 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [CountW-1:0] agent_count,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              req_type,
	input  wire logic [AgentW-1:0] agent,
	input  wire logic              res_take,
	output logic                   done,
	output rnra_res_t              res,
	output logic      [AW-1:0]     l_idx,
	output logic      [AW-1:0]     r_idx
);

	seq_st_t     state_q, state_d;
	logic [31:0] cfg_w;
	logic [NW-1:0] n_live;
	logic        bad_now;
	logic [AW-1:0] agent_idx;

	logic [AW-1:0] a_q, l_q, r_q, cand_q;
	logic        rel_q;
	phase_t      phase_q;
	agent_st_t   sl_q;
	rnra_res_t   res_q;

	logic [AW-1:0] nbr_idx;
	dir_t        nbr_dir;
	logic [AW-1:0] nbr_y;

	logic        we;
	logic [AW-1:0] waddr;
	agent_st_t   wdata;
	logic [AW-1:0] raddr;
	agent_st_t   rdata;
	logic        grant;

	assign cfg_w = 32'(agent_count);

	always_comb begin
		if (cfg_w < 32'd2) begin
			n_live = NW'(2);
		end else if (cfg_w > 32'(MAX_AGENTS)) begin
			n_live = NW'(MAX_AGENTS);
		end else begin
			n_live = NW'(cfg_w);
		end
	end

	assign bad_now   = 32'(agent) >= 32'(n_live);
	assign agent_idx = AW'(32'(agent));
	assign grant     = (sl_q == AS_THINKING) && (rdata != AS_EATING);

	rnra_nbr #(
		.MAX_AGENTS (MAX_AGENTS),
		.AW         (AW),
		.NW         (NW)
	) u_nbr (
		.idx (nbr_idx),
		.n   (n_live),
		.dir (nbr_dir),
		.nbr (nbr_y)
	);

	rnra_state_mem #(
		.MAX_AGENTS (MAX_AGENTS),
		.AW         (AW)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr  (raddr),
		.rdata  (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		done     = 1'b0;
		nbr_idx  = a_q;
		nbr_dir  = DIR_LEFT;
		we       = 1'b0;
		waddr    = a_q;
		wdata    = AS_THINKING;
		raddr    = nbr_y;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = bad_now ? S_DONE : S_LEFT;
				end
			end
			S_LEFT: begin
				we      = 1'b1;
				wdata   = rel_q ? AS_THINKING : AS_HUNGRY;
				state_d = S_RIGHT;
			end
			S_RIGHT: begin
				nbr_dir = DIR_RIGHT;
				state_d = rel_q ? S_CHK_L : S_TRY_RL;
			end
			S_CHK_L: begin
				raddr   = l_q;
				state_d = S_CHK_LW;
			end
			S_CHK_LW: begin
				state_d = (rdata == AS_HUNGRY) ? S_TRY_RL : S_CHK_R;
			end
			S_CHK_R: begin
				raddr   = r_q;
				state_d = S_CHK_RW;
			end
			S_CHK_RW: begin
				state_d = (rdata == AS_HUNGRY) ? S_TRY_RL : S_DONE;
			end
			S_TRY_RL: begin
				nbr_idx = cand_q;
				state_d = S_TRY_RR;
			end
			S_TRY_RR: begin
				nbr_idx = cand_q;
				nbr_dir = DIR_RIGHT;
				state_d = S_TRY_EVAL;
			end
			S_TRY_EVAL: begin
				we      = grant;
				waddr   = cand_q;
				wdata   = AS_EATING;
				state_d = (phase_q == PH_LEFT) ? S_CHK_R : S_DONE;
			end
			S_DONE: begin
				done = 1'b1;
				if (res_take) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					a_q   <= agent_idx;
					rel_q <= req_type;
					res_q <= '{self_g: 1'b0, left_g: 1'b0, right_g: 1'b0, bad: bad_now};
				end
			end
			S_LEFT: l_q <= nbr_y;
			S_RIGHT: begin
				r_q     <= nbr_y;
				cand_q  <= a_q;
				phase_q <= PH_SELF;
			end
			S_CHK_LW: begin
				cand_q  <= l_q;
				phase_q <= PH_LEFT;
			end
			S_CHK_RW: begin
				cand_q  <= r_q;
				phase_q <= PH_RIGHT;
			end
			S_TRY_RR: sl_q <= rdata;
			S_TRY_EVAL: begin
				if (grant) begin
					unique case (phase_q)
						PH_SELF:  res_q.self_g  <= 1'b1;
						PH_LEFT:  res_q.left_g  <= 1'b1;
						PH_RIGHT: res_q.right_g <= 1'b1;
						default:  ;
					endcase
				end
			end
			default: ;
		endcase
	end

	assign res   = res_q;
	assign l_idx = l_q;
	assign r_idx = r_q;

endmodule

`default_nettype wire

// ----- rtl/ring_neighbour_resource_arbiter_top.sv -----
// channel   dir  handshake                 payload
// s_axis    in   s_axis_tvalid/tready      tdata: agent; tuser: req_type
// m_axis    out  m_axis_tvalid/tready      tdata: grants, neighbours; tuser: bad_index
// cfg       in   cfg_we                    cfg_data: agent_count
//
// The sequencer walks one state-memory read and one neighbour step per
// cycle until it reaches its final state. Reset clears all agents to
// thinking at once through per-entry valid bits. A waiting result holds
// the sequencer in its final state until the output register frees.
`default_nettype none

module ring_neighbour_resource_arbiter_top
	import rnra_pkg::*;
#(
	parameter int unsigned MAX_AGENTS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [CountW-1:0] cfg_data,
	input  wire logic              s_axis_tvalid,
	output logic                   s_axis_tready,
	input  wire logic [7:0]        s_axis_tdata,   // [3:0] agent
	input  wire logic [0:0]        s_axis_tuser,   // [0] req_type
	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	output logic      [15:0]       m_axis_tdata,   // [0] self_granted, [1] left_granted,
	                                               // [2] right_granted, [6:3] left_index,
	                                               // [10:7] right_index
	output logic      [0:0]        m_axis_tuser    // [0] bad_index
);

	localparam int unsigned AW = $clog2(MAX_AGENTS);

	logic [CountW-1:0] agent_count_q;
	logic              res_take;
	logic              done;
	rnra_res_t         res;
	logic [AW-1:0]     l_idx, r_idx;

	logic              out_valid_q;
	rnra_res_t         out_res_q;
	logic [IdxOutW-1:0] out_l_q, out_r_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			agent_count_q <= CountReset;
		end else if (cfg_we) begin
			agent_count_q <= cfg_data;
		end
	end

	assign res_take = !out_valid_q || m_axis_tready;

	rnra_seq #(
		.MAX_AGENTS (MAX_AGENTS)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.agent_count (agent_count_q),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.req_type    (s_axis_tuser[0]),
		.agent       (s_axis_tdata[AgentW-1:0]),
		.res_take    (res_take),
		.done        (done),
		.res         (res),
		.l_idx       (l_idx),
		.r_idx       (r_idx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= done;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && done) begin
			out_res_q <= res;
			out_l_q   <= res.bad ? '0 : IdxOutW'(32'(l_idx));
			out_r_q   <= res.bad ? '0 : IdxOutW'(32'(r_idx));
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'd0, out_r_q, out_l_q,
		out_res_q.right_g, out_res_q.left_g, out_res_q.self_g};
	assign m_axis_tuser  = out_res_q.bad;

`ifndef SYNTHESIS
	a_bad_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 16'd0)
		else $error("bad index word carries payload");

	a_grant_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tdata[0] && (m_axis_tdata[1] || m_axis_tdata[2])))
		else $error("acquire and release grants in one word");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input ready while sequencer busy");
`endif

endmodule

`default_nettype wire
